// ===== sv/i2c_eeprom_master_sequencer_assert.svh =====
// Assertion macros shared by the sequencer RTL.
// Both macros expect clk and arst_n in scope.
`ifndef I2C_EEPROM_MASTER_SEQUENCER_ASSERT_SVH
`define I2C_EEPROM_MASTER_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CEM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2CEM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/i2cem_pkg.sv =====
`default_nettype none

package i2cem_pkg;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_START_A     = 4'd1;
	localparam logic [3:0] PH_START_B     = 4'd2;
	localparam logic [3:0] PH_TX_LOW      = 4'd3;
	localparam logic [3:0] PH_TX_HIGH     = 4'd4;
	localparam logic [3:0] PH_ACKIN_LOW   = 4'd5;
	localparam logic [3:0] PH_ACKIN_HIGH  = 4'd6;
	localparam logic [3:0] PH_RX_LOW      = 4'd7;
	localparam logic [3:0] PH_RX_HIGH     = 4'd8;
	localparam logic [3:0] PH_ACKOUT_LOW  = 4'd9;
	localparam logic [3:0] PH_ACKOUT_HIGH = 4'd10;
	localparam logic [3:0] PH_STOP_A      = 4'd11;
	localparam logic [3:0] PH_STOP_B      = 4'd12;
	localparam logic [3:0] PH_STOP_C      = 4'd13;
	localparam logic [3:0] PH_WAIT        = 4'd14;
	localparam logic [3:0] PH_RSTART_LOW  = 4'd15;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_WAIT_TICKS = 1'd1;

	localparam logic [6:0]  DEVICE_ADDRESS_RESET   = 7'd80;
	localparam logic [15:0] WRITE_WAIT_TICKS_RESET = 16'd1000;
	localparam logic [4:0]  COUNT_LIMIT            = 5'd16;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] buffer_index;
		logic [7:0] write_byte;
		logic [7:0] sub_address;
		logic [4:0] byte_count;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_release;
		logic       read_valid;
		logic [7:0] read_byte;
		logic [3:0] read_index;
		logic       ack_missing;
		logic       busy_res;
		logic       done_res;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/i2cem_chan_if.sv =====
`default_nettype none

interface i2cem_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/i2cem_wbuf.sv =====
`default_nettype none

module i2cem_wbuf #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/i2cem_core.sv =====
`default_nettype none

module i2cem_core #(
	parameter int BUFFER_DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire i2cem_pkg::item_t              item,
	input  wire logic                          cfg_we,
	input  wire logic [i2cem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [i2cem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic [7:0]                    wbuf_rdata,
	output logic                               wbuf_we,
	output logic [AW-1:0]                      wbuf_waddr,
	output logic [7:0]                         wbuf_wdata,
	output logic [AW-1:0]                      wbuf_raddr,
	output i2cem_pkg::res_t                    res
);

	import i2cem_pkg::*;

	logic [6:0]    dev_q;
	logic [15:0]   wait_ticks_q;
	logic [3:0]    phase_q, phase_d;
	logic [3:0]    bit_q, bit_d;
	logic [4:0]    byte_q, byte_d;
	logic [7:0]    shift_q, shift_d;
	logic [7:0]    sub_q, sub_d;
	logic [4:0]    count_q, count_d;
	logic          read_mode_q, read_mode_d;
	logic [15:0]   wait_q, wait_d;
	logic          ack_q, ack_d;
	logic [AW-1:0] ptr_q, ptr_d;

	logic          load_ok;
	logic          rvalid;
	logic [7:0]    rbyte;
	logic [3:0]    ridx;
	logic          done;
	logic [4:0]    byte_inc;
	logic [3:0]    bit_inc;
	logic [4:0]    count_clamped;
	logic          sda_out;
	logic          scl_out;
	logic          ack_bit;

	function automatic logic [7:0] tx_byte(input logic [4:0] bc, input logic rm,
			input logic [6:0] dev, input logic [7:0] sub, input logic [7:0] bbyte);
		logic [7:0] b;
		if (bc == 5'd0) begin
			b = {dev, 1'b0};
		end else if (bc == 5'd1) begin
			b = sub;
		end else if (rm) begin
			b = {dev, 1'b1};
		end else begin
			b = bbyte;
		end
		return b;
	endfunction

	function automatic logic last_read(input logic [4:0] bc, input logic [4:0] hc);
		return {1'b0, bc} >= ({1'b0, hc} + 6'd2);
	endfunction

	assign byte_inc   = byte_q + 5'd1;
	assign bit_inc    = bit_q + 4'd1;
	assign load_ok    = (phase_q == PH_IDLE)
		&& (9'(item.buffer_index) < 9'(BUFFER_DEPTH));
	assign wbuf_we    = step && (item.kind == KIND_LOAD) && load_ok;
	assign wbuf_waddr = AW'(item.buffer_index);
	assign wbuf_wdata = item.write_byte;
	assign wbuf_raddr = ptr_q;

	always_comb begin
		if (item.byte_count == 5'd0) begin
			count_clamped = 5'd1;
		end else if (item.byte_count > COUNT_LIMIT) begin
			count_clamped = COUNT_LIMIT;
		end else begin
			count_clamped = item.byte_count;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		bit_d       = bit_q;
		byte_d      = byte_q;
		shift_d     = shift_q;
		sub_d       = sub_q;
		count_d     = count_q;
		read_mode_d = read_mode_q;
		wait_d      = wait_q;
		ack_d       = ack_q;
		ptr_d       = ptr_q;
		rvalid      = 1'b0;
		rbyte       = 8'd0;
		ridx        = 4'd0;
		done        = 1'b0;
		unique case (item.kind)
			KIND_LOAD: begin
			end
			KIND_WRITE, KIND_READ: begin
				if (phase_q == PH_IDLE) begin
					sub_d       = item.sub_address;
					count_d     = count_clamped;
					read_mode_d = (item.kind == KIND_READ);
					byte_d      = 5'd0;
					bit_d       = 4'd0;
					shift_d     = 8'd0;
					wait_d      = 16'd0;
					ack_d       = 1'b0;
					ptr_d       = '0;
					phase_d     = PH_START_A;
				end
			end
			KIND_TICK: begin
				unique case (phase_q)
					PH_IDLE:       phase_d = PH_IDLE;
					PH_START_A:    phase_d = PH_START_B;
					PH_START_B: begin
						shift_d = tx_byte(byte_q, read_mode_q, dev_q, sub_q, wbuf_rdata);
						bit_d   = 4'd0;
						phase_d = PH_TX_LOW;
					end
					PH_TX_LOW:     phase_d = PH_TX_HIGH;
					PH_TX_HIGH: begin
						bit_d   = bit_inc;
						shift_d = {shift_q[6:0], 1'b0};
						phase_d = (bit_inc >= 4'd8) ? PH_ACKIN_LOW : PH_TX_LOW;
					end
					PH_ACKIN_LOW: begin
						if (item.sda_in) begin
							ack_d = 1'b1;
						end
						phase_d = PH_ACKIN_HIGH;
					end
					PH_ACKIN_HIGH: begin
						byte_d = byte_inc;
						if (!read_mode_q) begin
							if ({1'b0, byte_inc} < ({1'b0, count_q} + 6'd2)) begin
								shift_d = tx_byte(byte_inc, read_mode_q, dev_q, sub_q,
									wbuf_rdata);
								bit_d   = 4'd0;
								phase_d = PH_TX_LOW;
								if (byte_inc >= 5'd2) begin
									ptr_d = (ptr_q == AW'(BUFFER_DEPTH - 1)) ? '0
										: ptr_q + 1'b1;
								end
							end else begin
								phase_d = PH_STOP_A;
							end
						end else if (byte_inc == 5'd1) begin
							shift_d = tx_byte(byte_inc, read_mode_q, dev_q, sub_q, wbuf_rdata);
							bit_d   = 4'd0;
							phase_d = PH_TX_LOW;
						end else if (byte_inc == 5'd2) begin
							phase_d = PH_RSTART_LOW;
						end else begin
							bit_d   = 4'd0;
							shift_d = 8'd0;
							phase_d = PH_RX_LOW;
						end
					end
					PH_RSTART_LOW: phase_d = PH_START_A;
					PH_RX_LOW: begin
						shift_d = {shift_q[6:0], item.sda_in};
						bit_d   = bit_inc;
						if (bit_inc >= 4'd8) begin
							rvalid = 1'b1;
							rbyte  = {shift_q[6:0], item.sda_in};
							ridx   = 4'(byte_q - 5'd3);
						end
						phase_d = PH_RX_HIGH;
					end
					PH_RX_HIGH:    phase_d = (bit_q >= 4'd8) ? PH_ACKOUT_LOW : PH_RX_LOW;
					PH_ACKOUT_LOW: phase_d = PH_ACKOUT_HIGH;
					PH_ACKOUT_HIGH: begin
						if (last_read(byte_q, count_q)) begin
							phase_d = PH_STOP_A;
						end else begin
							byte_d  = byte_inc;
							bit_d   = 4'd0;
							shift_d = 8'd0;
							phase_d = PH_RX_LOW;
						end
					end
					PH_STOP_A:     phase_d = PH_STOP_B;
					PH_STOP_B:     phase_d = PH_STOP_C;
					PH_STOP_C: begin
						if (!read_mode_q && (wait_ticks_q != 16'd0)) begin
							wait_d  = wait_ticks_q;
							phase_d = PH_WAIT;
						end else begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					end
					PH_WAIT: begin
						if (wait_q <= 16'd1) begin
							wait_d  = 16'd0;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							wait_d = wait_q - 16'd1;
						end
					end
				endcase
			end
		endcase
	end

	assign ack_bit = last_read(byte_d, count_d);

	always_comb begin
		unique case (phase_d)
			PH_START_B:     begin scl_out = 1'b1; sda_out = 1'b0;       end
			PH_TX_LOW:      begin scl_out = 1'b0; sda_out = shift_d[7]; end
			PH_TX_HIGH:     begin scl_out = 1'b1; sda_out = shift_d[7]; end
			PH_ACKIN_LOW:   begin scl_out = 1'b0; sda_out = 1'b1;       end
			PH_RX_LOW:      begin scl_out = 1'b0; sda_out = 1'b1;       end
			PH_ACKOUT_LOW:  begin scl_out = 1'b0; sda_out = ack_bit;    end
			PH_ACKOUT_HIGH: begin scl_out = 1'b1; sda_out = ack_bit;    end
			PH_STOP_A:      begin scl_out = 1'b0; sda_out = 1'b0;       end
			PH_STOP_B:      begin scl_out = 1'b1; sda_out = 1'b0;       end
			PH_RSTART_LOW:  begin scl_out = 1'b0; sda_out = 1'b1;       end
			default:        begin scl_out = 1'b1; sda_out = 1'b1;       end
		endcase
	end

	always_comb begin
		res.scl         = scl_out;
		res.sda_release = sda_out;
		res.read_valid  = rvalid;
		res.read_byte   = rbyte;
		res.read_index  = ridx;
		res.ack_missing = ack_d;
		res.busy_res    = (phase_d != PH_IDLE);
		res.done_res    = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q        <= DEVICE_ADDRESS_RESET;
			wait_ticks_q <= WRITE_WAIT_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS:   dev_q        <= cfg_wdata[6:0];
				CFG_WRITE_WAIT_TICKS: wait_ticks_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 4'd0;
			byte_q      <= 5'd0;
			shift_q     <= 8'd0;
			sub_q       <= 8'd0;
			count_q     <= 5'd0;
			read_mode_q <= 1'b0;
			wait_q      <= 16'd0;
			ack_q       <= 1'b0;
			ptr_q       <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_q       <= bit_d;
			byte_q      <= byte_d;
			shift_q     <= shift_d;
			sub_q       <= sub_d;
			count_q     <= count_d;
			read_mode_q <= read_mode_d;
			wait_q      <= wait_d;
			ack_q       <= ack_d;
			ptr_q       <= ptr_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/i2c_eeprom_master_sequencer.sv =====
// I2C master sequencer for a serial EEPROM: random read and page write.
// Items arrive on in_ch as valid/ready beats. A tick beat moves the bus one
// half-bit phase and carries the sampled SDA level; load beats fill the write
// buffer; start beats open a write or read transfer when the block is idle.
// Every input beat yields exactly one result beat on out_ch, carrying the
// SCL and SDA levels for the new phase, any received byte, the missing-ack
// flag, busy and a done marker on the beat that returns the block to idle.
// Configuration (device address, post-write wait) is written through cfg_we/
// cfg_index/cfg_wdata only while idle; the user, not the block, enforces it.
// Each input beat passes through the input register; the phase logic then
// computes its result from that register and writes the result register.
// Throughput is one beat per cycle while out_ch does not stall; the input
// and result registers let a new beat enter while a finished result waits.
// When out_ch stalls, the result holds, the input register fills and in_ch
// ready drops; nothing is lost. Reset empties both registers, returns the
// bus to idle (SCL and SDA released) and restores the configuration defaults.
// The buffer has no reset; its read port is registered and prefetched.
`default_nettype none

module i2c_eeprom_master_sequencer #(
	parameter int BUFFER_DEPTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	i2cem_chan_if.sink                             in_ch,
	i2cem_chan_if.source                           out_ch,
	input  wire logic                              cfg_we,
	input  wire logic [i2cem_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [i2cem_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	import i2cem_pkg::*;

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	item_t         item_s1;
	logic          valid_s1;
	res_t          res_q;
	logic          out_valid_q;
	res_t          res_d;
	logic          advance;
	logic          wbuf_we;
	logic [AW-1:0] wbuf_waddr;
	logic [7:0]    wbuf_wdata;
	logic [AW-1:0] wbuf_raddr;
	logic [7:0]    wbuf_rdata;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= in_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	i2cem_core #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW(AW)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.wbuf_rdata(wbuf_rdata),
		.wbuf_we(wbuf_we),
		.wbuf_waddr(wbuf_waddr),
		.wbuf_wdata(wbuf_wdata),
		.wbuf_raddr(wbuf_raddr),
		.res(res_d)
	);

	i2cem_wbuf #(
		.DEPTH(BUFFER_DEPTH),
		.AW(AW)
	) u_wbuf (
		.clk(clk),
		.we(wbuf_we),
		.waddr(wbuf_waddr),
		.wdata(wbuf_wdata),
		.raddr(wbuf_raddr),
		.rdata(wbuf_rdata)
	);

`include "i2c_eeprom_master_sequencer_assert.svh"

	`I2CEM_ASSERT_NOW(a_done_idle, out_valid_q && res_q.done_res, !res_q.busy_res, "done while busy")
	`I2CEM_ASSERT_NOW(a_rx_phase, out_valid_q && res_q.read_valid, res_q.busy_res && res_q.scl, "read byte outside receive phase")
	`I2CEM_ASSERT_NEXT(a_result_loaded, advance, out_valid_q, "processed beat produced no result")

endmodule

`default_nettype wire
